### sv/pfn_pkg.sv
// Package: shared types, sizes and the prototype filter tap generator.
`timescale 1ns / 1ps
`default_nettype none

package pfn_pkg;

    // Sizes
    localparam int VectorLen = 256;
    localparam int Overlap   = 4;
    localparam int TapCount  = Overlap * VectorLen;
    localparam int PosW      = $clog2(VectorLen);
    localparam int SampleW   = 16;
    localparam int TapW      = 16;
    localparam int ProdW     = 17;
    localparam int SumW      = ProdW + 2;
    localparam int OutW      = 18;
    localparam int OutMax    = 2 ** (OutW - 1) - 1;
    localparam int OutMin    = -(2 ** (OutW - 1));

    // Prototype filter constants, Q30
    localparam longint Q30One    = 64'sd1073741824;
    localparam longint CoefA1    = 64'sd1043633921;
    localparam longint CoefA2    = 64'sd759250125;
    localparam longint CoefA3    = 64'sd252487115;
    localparam longint HalfPiQ30 = 64'sd1686629713;
    localparam longint TapDen    = Q30One + 2 * (CoefA1 + CoefA2 + CoefA3);
    localparam longint TapDenHalf = TapDen / 2;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic signed [TapW-1:0]    tap_t;
    typedef logic signed [ProdW-1:0]   prod_t;
    typedef logic signed [OutW-1:0]    out_t;
    typedef logic [PosW-1:0]           pos_t;

    typedef struct packed {
        sample_t re;
        sample_t im;
    } cplx_t;

    // One delay memory row: the older samples at one position, index 0 newest
    typedef cplx_t [Overlap-2:0] row_t;

    // Delay memory access command
    typedef struct packed {
        logic rd_en;
        pos_t rd_addr;
        logic wr_en;
        pos_t wr_addr;
    } ram_cmd_t;

    // Cosine series in Q30, x in [0, pi/2)
    function automatic longint cos_series(longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) >>> 30;
        term = Q30One;
        sum  = term;
        term = ((term * x2) >>> 30) / 2;   sum = sum - term;
        term = ((term * x2) >>> 30) / 12;  sum = sum + term;
        term = ((term * x2) >>> 30) / 30;  sum = sum - term;
        term = ((term * x2) >>> 30) / 56;  sum = sum + term;
        term = ((term * x2) >>> 30) / 90;  sum = sum - term;
        term = ((term * x2) >>> 30) / 132; sum = sum + term;
        term = ((term * x2) >>> 30) / 182; sum = sum - term;
        return sum;
    endfunction

    // Sine series in Q30, x in [0, pi/2)
    function automatic longint sin_series(longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = term;
        term = ((term * x2) >>> 30) / 6;   sum = sum - term;
        term = ((term * x2) >>> 30) / 20;  sum = sum + term;
        term = ((term * x2) >>> 30) / 42;  sum = sum - term;
        term = ((term * x2) >>> 30) / 72;  sum = sum + term;
        term = ((term * x2) >>> 30) / 110; sum = sum - term;
        term = ((term * x2) >>> 30) / 156; sum = sum + term;
        term = ((term * x2) >>> 30) / 210; sum = sum - term;
        return sum;
    endfunction

    // cos(2*pi*j/TapCount) in Q30 with quadrant reduction
    function automatic longint cos_turn(longint j);
        longint jm;
        longint q;
        longint r;
        longint th;
        longint res;
        jm = j % TapCount;
        q  = jm / VectorLen;
        r  = jm % VectorLen;
        th = (HalfPiQ30 * r + VectorLen / 2) / VectorLen;
        case (q)
            0:       res = cos_series(th);
            1:       res = -sin_series(th);
            2:       res = -cos_series(th);
            default: res = sin_series(th);
        endcase
        return res;
    endfunction

    // a*c in Q30, a >= 0, rounded half away from zero
    function automatic longint mul_q30(longint a, longint c);
        longint mag;
        longint p;
        mag = (c < 0) ? -c : c;
        p   = (a * mag + (64'sd1 <<< 29)) >>> 30;
        return (c < 0) ? -p : p;
    endfunction

    // One prototype filter tap, Q1.15, saturated
    function automatic tap_t tap_value(longint i);
        longint num;
        longint mag;
        longint t;
        longint v;
        num = Q30One
            - 2 * mul_q30(CoefA1, cos_turn(i))
            + 2 * mul_q30(CoefA2, cos_turn(2 * i))
            - 2 * mul_q30(CoefA3, cos_turn(3 * i));
        mag = (num < 0) ? -num : num;
        t   = (mag * 32768 + TapDenHalf) / TapDen;
        if (num < 0)
        begin
            v = (t > 32768) ? -32768 : -t;
        end
        else
        begin
            v = (t > 32767) ? 32767 : t;
        end
        if (i == 0)
        begin
            v = 0;
        end
        return v[TapW-1:0];
    endfunction

    // Sample times tap, rounded to Q.15 (add half, floor)
    function automatic prod_t round_prod(sample_t s, tap_t t);
        logic signed [31:0] p;
        p = 32'(s) * 32'(t);
        p = p + 32'sd16384;
        return p[31:15];
    endfunction

endpackage

`default_nettype wire

### sv/pfn_sample_if.sv
// Interface: input sample channel.
`timescale 1ns / 1ps
`default_nettype none

interface pfn_sample_if
    import pfn_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_re;
    sample_t sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

`default_nettype wire

### sv/pfn_result_if.sv
// Interface: filtered result channel.
`timescale 1ns / 1ps
`default_nettype none

interface pfn_result_if
    import pfn_pkg::*;
();
    logic valid;
    logic ready;
    out_t out_re;
    out_t out_im;
    logic vector_end;

    modport source (output valid, output out_re, output out_im, output vector_end,
                    input ready);
    modport sink   (input valid, input out_re, input out_im, input vector_end,
                    output ready);
endinterface

`default_nettype wire

### sv/pfn_cfg_if.sv
// Interface: configuration write channel for the mirror register.
`timescale 1ns / 1ps
`default_nettype none

interface pfn_cfg_if;
    logic valid;
    logic ready;
    logic mirror_taps;

    modport source (output valid, output mirror_taps, input ready);
    modport sink   (input valid, input mirror_taps, output ready);
endinterface

`default_nettype wire

### sv/pfn_tap_rom.sv
// Tap ROM: four prototype filter segments, one registered read per segment.
`timescale 1ns / 1ps
`default_nettype none

module pfn_tap_rom
    import pfn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rd_en,
    input  wire pos_t col,
    output tap_t      taps [Overlap]
);

    tap_t rom [Overlap][VectorLen];
    tap_t taps_reg [Overlap];

    // Fill the segments with the prototype filter at elaboration
    for (genvar g_seg = 0; g_seg < Overlap; g_seg++)
    begin : g_seg_blk
        for (genvar g_col = 0; g_col < VectorLen; g_col++)
        begin : g_col_blk
            localparam tap_t TapVal = tap_value(longint'(g_seg * VectorLen + g_col));
            assign rom[g_seg][g_col] = TapVal;
        end
    end

    // Read all segments at the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int k = 0; k < Overlap; k++)
            begin
                taps_reg[k] <= rom[k][col];
            end
        end
    end

    assign taps = taps_reg;

endmodule

`default_nettype wire

### sv/pfn_delay_ram.sv
// Delay memory: older samples per vector position, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none

module pfn_delay_ram
    import pfn_pkg::*;
(
    input  wire logic     clk,
    input  wire ram_cmd_t cmd,
    input  wire row_t     wr_row,
    output row_t          rd_row
);

    row_t mem [VectorLen];
    row_t rd_row_reg;

    // Write back the shifted row
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wr_row;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_row_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

### sv/polyphase_filter_network.sv
// Top level: overlap-4 polyphase filter network with delay memory and tap ROM.
//
//  Channel   Dir  Beat payload                       Beat when
//  samples   in   sample_re, sample_im (Q1.15)       valid && ready
//  results   out  out_re, out_im (Q3.15), vector_end valid && ready
//  cfg       in   mirror_taps                        valid && ready (ready tied high)
//
// One sample per cycle sustained unless results stall. Results pass stage 1, stage 2
// and the output register. Throughput is set by the single read and write port of
// the delay memory, used once per sample (read at accept, write as stage 1 leaves).
// After reset the older vectors read as zero through a fill flag; no clearing pass.
// Stalls on results back up stage by stage; empty stages absorb them first.
`timescale 1ns / 1ps
`default_nettype none

module polyphase_filter_network
    import pfn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    pfn_sample_if.sink    samples,
    pfn_result_if.source  results,
    pfn_cfg_if.sink       cfg
);

    localparam pos_t PosLast = pos_t'(VectorLen - 1);

    // Handshake
    logic accept;
    logic rdy1;
    logic rdy2;
    logic rdy3;

    // Control state
    logic mirror_reg;
    pos_t pos_reg;
    pos_t pos_next;
    logic fill_reg;
    logic fill_next;
    pos_t col;

    // Stage 1: sample, position, memory and ROM read data
    logic  s1_valid_reg;
    cplx_t s1_x_reg;
    pos_t  s1_pos_reg;
    logic  s1_end_reg;
    logic  s1_fill_reg;
    row_t  rd_row;
    row_t  hist;
    row_t  wr_row;
    tap_t  taps [Overlap];
    cplx_t lane [Overlap];
    ram_cmd_t ram_cmd;

    // Stage 2: rounded products
    logic  s2_valid_reg;
    logic  s2_end_reg;
    prod_t s2_re_reg [Overlap];
    prod_t s2_im_reg [Overlap];

    // Output register
    logic out_valid_reg;
    out_t out_re_reg;
    out_t out_im_reg;
    logic out_end_reg;
    logic signed [SumW-1:0] sum_re;
    logic signed [SumW-1:0] sum_im;
    out_t sat_re;
    out_t sat_im;

    // Stage-by-stage ready chain
    assign rdy3   = !out_valid_reg || results.ready;
    assign rdy2   = !s2_valid_reg || rdy3;
    assign rdy1   = !s1_valid_reg || rdy2;
    assign accept = samples.valid && rdy1;
    assign samples.ready = rdy1;

    // Configuration: always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            mirror_reg <= cfg.mirror_taps;
        end
    end

    // Advance position and set the fill flag after the first vector
    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            pos_next = (pos_reg == PosLast) ? '0 : pos_reg + pos_t'(1);
            if (pos_reg == PosLast)
            begin
                fill_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    // Tap column, reversed within each segment when mirrored
    assign col = mirror_reg ? (PosLast - pos_reg) : pos_reg;

    pfn_tap_rom u_tap_rom (
        .clk   (clk),
        .rd_en (accept),
        .col   (col),
        .taps  (taps)
    );

    // Memory commands: read at accept, write back as stage 1 leaves
    always_comb
    begin
        ram_cmd.rd_en   = accept;
        ram_cmd.rd_addr = pos_reg;
        ram_cmd.wr_en   = s1_valid_reg && rdy2;
        ram_cmd.wr_addr = s1_pos_reg;
    end

    pfn_delay_ram u_delay_ram (
        .clk    (clk),
        .cmd    (ram_cmd),
        .wr_row (wr_row),
        .rd_row (rd_row)
    );

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg.re <= samples.sample_re;
            s1_x_reg.im <= samples.sample_im;
            s1_pos_reg  <= pos_reg;
            s1_end_reg  <= (pos_reg == PosLast);
            s1_fill_reg <= fill_reg;
        end
    end

    // Drop unwritten history in the first vector, shift in the new sample
    always_comb
    begin
        hist = s1_fill_reg ? rd_row : '0;
        wr_row[0] = s1_x_reg;
        for (int k = 1; k < Overlap - 1; k++)
        begin
            wr_row[k] = hist[k-1];
        end
        lane[0] = s1_x_reg;
        for (int k = 1; k < Overlap; k++)
        begin
            lane[k] = hist[k-1];
        end
    end

    // Stage 2: one multiplier per lane and part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            s2_end_reg <= s1_end_reg;
            for (int k = 0; k < Overlap; k++)
            begin
                s2_re_reg[k] <= round_prod(lane[k].re, taps[k]);
                s2_im_reg[k] <= round_prod(lane[k].im, taps[k]);
            end
        end
    end

    // Sum the lanes and saturate
    always_comb
    begin
        sum_re = '0;
        sum_im = '0;
        for (int k = 0; k < Overlap; k++)
        begin
            sum_re = sum_re + SumW'(s2_re_reg[k]);
            sum_im = sum_im + SumW'(s2_im_reg[k]);
        end
        if (sum_re > SumW'(OutMax))
        begin
            sat_re = out_t'(OutMax);
        end
        else if (sum_re < SumW'(OutMin))
        begin
            sat_re = out_t'(OutMin);
        end
        else
        begin
            sat_re = sum_re[OutW-1:0];
        end
        if (sum_im > SumW'(OutMax))
        begin
            sat_im = out_t'(OutMax);
        end
        else if (sum_im < SumW'(OutMin))
        begin
            sat_im = out_t'(OutMin);
        end
        else
        begin
            sat_im = sum_im[OutW-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            out_re_reg  <= sat_re;
            out_im_reg  <= sat_im;
            out_end_reg <= s2_end_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_re     = out_re_reg;
    assign results.out_im     = out_im_reg;
    assign results.vector_end = out_end_reg;

    // Checks
    a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        ram_cmd.wr_en && ram_cmd.rd_en |-> ram_cmd.wr_addr != ram_cmd.rd_addr)
        else $error("delay memory read and write hit the same row");

    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos_reg == PosLast |=> pos_reg == '0 && fill_reg)
        else $error("position did not wrap at vector end");

    a_fill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg |=> fill_reg)
        else $error("fill flag dropped");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result without a product stage beat");

endmodule

`default_nettype wire

### verif/tb.sv
// Testbench for the polyphase filter network: directed and random samples against a tap predictor.
`timescale 1ns / 1ps

module tb
    import pfn_pkg::*;
();

    // Filter geometry and prototype filter constants, Q30
    localparam int     VecLen     = 256;
    localparam int     Taps       = 4 * VecLen;
    localparam int     OldVecs    = 3;
    localparam longint One30      = 64'sd1073741824;
    localparam longint A1         = 64'sd1043633921;
    localparam longint A2         = 64'sd759250125;
    localparam longint A3         = 64'sd252487115;
    localparam longint HalfPi30   = 64'sd1686629713;
    localparam longint SumMax     = 131071;
    localparam longint SumMin     = -131072;
    localparam int     CycleLimit = 200000;
    localparam int     ShowLimit  = 10;

    typedef struct {
        out_t re;
        out_t im;
        logic last;
    } filt_out_t;

    logic      clk;
    logic      rst_n;
    bit        no_idle;
    int        bad_beats;
    int        cycles;
    int        tap_q15[Taps];
    sample_t   hist_re[OldVecs][VecLen];
    sample_t   hist_im[OldVecs][VecLen];
    int        phase_pos;
    bit        mirror_now;
    filt_out_t filt_expected[$];

    pfn_sample_if sample_ch();
    pfn_result_if result_ch();
    pfn_cfg_if    cfg_ch();

    polyphase_filter_network i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // Alternating Taylor series in Q30, eight terms, each term truncated
    function automatic longint taylor_q30(longint x, longint first, longint n);
        longint x2;
        longint term;
        longint acc;
        int     i;
        x2   = (x * x) >>> 30;
        term = first;
        acc  = term;
        for (i = 1; i < 8; i++)
        begin
            term = ((term * x2) >>> 30) / ((n + 1) * (n + 2));
            n    = n + 2;
            acc  = (i % 2 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    // cos(2*pi*j/Taps) in Q30, reduced to the first quadrant
    function automatic longint cos_q30(longint j);
        longint jm;
        longint r;
        longint th;
        longint c;
        jm = j % Taps;
        r  = jm % VecLen;
        th = (HalfPi30 * r + VecLen / 2) / VecLen;
        case (jm / VecLen)
            0:       c = taylor_q30(th, One30, 0);
            1:       c = -taylor_q30(th, th, 1);
            2:       c = -taylor_q30(th, One30, 0);
            default: c = taylor_q30(th, th, 1);
        endcase
        return c;
    endfunction

    // a*c in Q30, rounded half away from zero
    function automatic longint scale_q30(longint a, longint c);
        longint mag;
        longint p;
        mag = (c < 0) ? -c : c;
        p   = (a * mag + (64'sd1 <<< 29)) >>> 30;
        return (c < 0) ? -p : p;
    endfunction

    // Fill the prototype tap table, Q1.15 with saturation
    function automatic void build_taps();
        longint den;
        longint num;
        longint mag;
        longint t;
        int     i;
        den        = One30 + 2 * (A1 + A2 + A3);
        tap_q15[0] = 0;
        for (i = 1; i < Taps; i++)
        begin
            num = One30
                - 2 * scale_q30(A1, cos_q30(i))
                + 2 * scale_q30(A2, cos_q30(2 * i))
                - 2 * scale_q30(A3, cos_q30(3 * i));
            mag = (num < 0) ? -num : num;
            t   = (mag * 32768 + den / 2) / den;
            if (num < 0)
            begin
                tap_q15[i] = (t > 32768) ? -32768 : -int'(t);
            end
            else
            begin
                tap_q15[i] = (t > 32767) ? 32767 : int'(t);
            end
        end
    endfunction

    // Sample times tap, rounded to Q.15 by adding half and flooring
    function automatic longint tap_product(sample_t s, int t);
        longint p;
        p = longint'(s) * longint'(t);
        return (p + 16384) >>> 15;
    endfunction

    function automatic out_t clip18(longint v);
        if (v > SumMax)
        begin
            v = SumMax;
        end
        if (v < SumMin)
        begin
            v = SumMin;
        end
        return out_t'(v);
    endfunction

    // Filter one sample at the current position and advance the history
    function automatic filt_out_t filter_sample(sample_t re, sample_t im);
        filt_out_t res;
        longint    acc_re;
        longint    acc_im;
        int        col;
        int        t;
        int        k;
        col    = mirror_now ? (VecLen - 1 - phase_pos) : phase_pos;
        acc_re = tap_product(re, tap_q15[col]);
        acc_im = tap_product(im, tap_q15[col]);
        for (k = 1; k <= OldVecs; k++)
        begin
            t      = tap_q15[k * VecLen + col];
            acc_re = acc_re + tap_product(hist_re[k-1][phase_pos], t);
            acc_im = acc_im + tap_product(hist_im[k-1][phase_pos], t);
        end
        for (k = OldVecs - 1; k > 0; k--)
        begin
            hist_re[k][phase_pos] = hist_re[k-1][phase_pos];
            hist_im[k][phase_pos] = hist_im[k-1][phase_pos];
        end
        hist_re[0][phase_pos] = re;
        hist_im[0][phase_pos] = im;
        res.re    = clip18(acc_re);
        res.im    = clip18(acc_im);
        res.last  = (phase_pos == VecLen - 1);
        phase_pos = (phase_pos == VecLen - 1) ? 0 : phase_pos + 1;
        return res;
    endfunction

    // Mostly full-range values, with the extremes and zero mixed in
    function automatic sample_t pick_sample();
        sample_t v;
        case ($urandom_range(9))
            0:       v = 16'sh7FFF;
            1:       v = 16'sh8000;
            2:       v = '0;
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    // Drive one sample beat, with an occasional idle cycle in front
    task automatic send_sample(sample_t re, sample_t im);
        if (!no_idle && $urandom_range(99) < 9)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_re <= re;
        sample_ch.sample_im <= im;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (filt_expected.size() != 0) @(posedge clk);
    endtask

    task automatic write_mirror(bit m);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.mirror_taps <= m;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Field extremes and alternating bit patterns, forward tap order
    task automatic test_field_extremes();
        sample_t vals[10] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                              16'sh4000, 16'shC000, 16'sh5555, 16'shAAAA, 16'sh7FFF};
        int i;
        write_mirror(1'b0);
        for (i = 0; i < 10; i++)
        begin
            send_sample(vals[i], vals[9 - i]);
        end
        drain_results();
    endtask

    // Field extremes again, with the taps mirrored inside each segment
    task automatic test_mirror_extremes();
        sample_t vals[10] = '{16'sh8000, 16'sh7FFF, 16'shAAAA, 16'sh5555, 16'shFFFF,
                              16'sh0000, 16'sh0001, 16'sh8000, 16'sh3FFF, 16'shC001};
        int i;
        write_mirror(1'b1);
        for (i = 0; i < 10; i++)
        begin
            send_sample(vals[i], vals[i]);
        end
        drain_results();
    endtask

    // Random stream across vector boundaries with one mirror setting
    task automatic test_random_stream(int count, bit m, bit steady);
        no_idle = steady;
        write_mirror(m);
        repeat (count) send_sample(pick_sample(), pick_sample());
        drain_results();
        no_idle = 1'b0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run timeout
    initial
    begin
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Track the mirror register, predict on sample beats, check result beats
    initial
    begin
        filt_out_t want;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                mirror_now = cfg_ch.mirror_taps;
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                filt_expected.push_back(filter_sample(sample_ch.sample_re,
                                                      sample_ch.sample_im));
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (filt_expected.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= ShowLimit)
                    begin
                        $display("unexpected result beat at cycle %0d: re=%0d im=%0d end=%0b",
                                 cycles, result_ch.out_re, result_ch.out_im,
                                 result_ch.vector_end);
                    end
                end
                else
                begin
                    want = filt_expected.pop_front();
                    if (result_ch.out_re !== want.re || result_ch.out_im !== want.im
                        || result_ch.vector_end !== want.last)
                    begin
                        bad_beats++;
                        if (bad_beats <= ShowLimit)
                        begin
                            $display({"result beat at cycle %0d: expected re=%0d im=%0d",
                                      " end=%0b, got re=%0d im=%0d end=%0b"},
                                     cycles, want.re, want.im, want.last,
                                     result_ch.out_re, result_ch.out_im,
                                     result_ch.vector_end);
                        end
                    end
                end
            end
            // Stall the result side now and then
            result_ch.ready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    // Test sequence
    initial
    begin
        int i;
        int j;
        bad_beats  = 0;
        no_idle    = 1'b0;
        phase_pos  = 0;
        mirror_now = 1'b0;
        for (i = 0; i < OldVecs; i++)
        begin
            for (j = 0; j < VecLen; j++)
            begin
                hist_re[i][j] = '0;
                hist_im[i][j] = '0;
            end
        end
        build_taps();
        rst_n               = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_re = '0;
        sample_ch.sample_im = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.mirror_taps  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_mirror_extremes();
        test_random_stream(250, 1'b0, 1'b0);
        test_random_stream(250, 1'b1, 1'b1);
        test_random_stream(250, 1'b0, 1'b0);
        test_random_stream(150, 1'b1, 1'b0);

        // Let stray beats show up, then count leftovers
        repeat (8) @(posedge clk);
        bad_beats = bad_beats + filt_expected.size();
        if (bad_beats == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
